// ----- hdl/skl_pkg.sv -----
`default_nettype none

package skl_pkg;

    // Table geometry
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = 4;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Field widths
    localparam int FUNC_W = 3;
    localparam int RANK_W = 4;
    localparam int SUIT_W = 3;
    localparam int STAT_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT  = 3'd0,
        FN_LOOKUP  = 3'd1,
        FN_REM_POS = 3'd2,
        FN_REM_UNM = 3'd3,
        FN_REM_KEY = 3'd4,
        FN_MARK    = 3'd5
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_POS   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_APPLY
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic eval;
        logic apply;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- hdl/sorted_keyed_list_top.sv -----
// Each accepted transaction runs through accept, per-cell compare and shift/apply steps before its
// result is valid; the next one is accepted only after that, and the apply step waits while an
// earlier result still waits in the output register.
// Reset (i_rst_n low, synchronous): the table is emptied (count zero), the output
// register is cleared of valid data; entry cells keep whatever they held.
`default_nettype none

module sorted_keyed_list_top
    import skl_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire [FUNC_W-1:0]  i_func,
    input  wire [RANK_W-1:0]  i_rank_in,
    input  wire [SUIT_W-1:0]  i_suit_in,
    input  wire               i_keep_in,
    input  wire [POS_W-1:0]   i_position,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [RANK_W-1:0] o_rank_out,
    output logic [SUIT_W-1:0] o_suit_out,
    output logic              o_keep_out,
    output logic              o_is_empty,
    output logic [CNT_W-1:0]  o_entry_count
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer
    skl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Entry cells and result register
    skl_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_func        (i_func),
        .i_rank_in     (i_rank_in),
        .i_suit_in     (i_suit_in),
        .i_keep_in     (i_keep_in),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_rank_out    (o_rank_out),
        .o_suit_out    (o_suit_out),
        .o_keep_out    (o_keep_out),
        .o_is_empty    (o_is_empty),
        .o_entry_count (o_entry_count)
    );

endmodule

`default_nettype wire

// ----- hdl/skl_ctrl.sv -----
`default_nettype none

module skl_ctrl
    import skl_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
            end
            S_APPLY: begin
                o_cmd.apply = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/skl_dp.sv -----
`default_nettype none

module skl_dp
    import skl_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  wire [FUNC_W-1:0]  i_func,
    input  wire [RANK_W-1:0]  i_rank_in,
    input  wire [SUIT_W-1:0]  i_suit_in,
    input  wire               i_keep_in,
    input  wire [POS_W-1:0]   i_position,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [RANK_W-1:0] o_rank_out,
    output logic [SUIT_W-1:0] o_suit_out,
    output logic              o_keep_out,
    output logic              o_is_empty,
    output logic [CNT_W-1:0]  o_entry_count
);

    // Latched operation
    t_func             r_func;
    logic [RANK_W-1:0] r_rank;
    logic [SUIT_W-1:0] r_suit;
    logic              r_keep;
    logic [POS_W-1:0]  r_pos;

    // Entry cells
    logic [RANK_W-1:0] r_rank_c [DEPTH];
    logic [SUIT_W-1:0] r_suit_c [DEPTH];
    logic              r_keep_c [DEPTH];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    // Per-cell evaluation
    logic [DEPTH-1:0]  valid_v;
    logic [DEPTH-1:0]  gt_v;
    logic [DEPTH-1:0]  match_v;
    logic [DEPTH-1:0]  unm_v;
    logic [DEPTH-1:0]  atpos_v;
    logic [DEPTH-1:0]  sel_v;
    logic              found;
    logic [DEPTH-1:0]  r_sel;
    logic              r_found;
    logic [DEPTH-1:0]  first_v;

    // Removed entry and result
    logic [RANK_W-1:0] rem_rank;
    logic [SUIT_W-1:0] rem_suit;
    logic              rem_keep;
    logic              removes;
    t_status           res_status;

    // Output register
    logic              r_out_valid;
    t_status           r_out_status;
    logic [RANK_W-1:0] r_out_rank;
    logic [SUIT_W-1:0] r_out_suit;
    logic              r_out_keep;
    logic              r_out_empty;
    logic [CNT_W-1:0]  r_out_count;

    // Mark every position at or after the lowest set bit
    function automatic logic [DEPTH-1:0] prefix_or(input logic [DEPTH-1:0] v);
        logic [DEPTH-1:0] p;
        p = v;
        for (int s = 1; s < DEPTH; s = s * 2) begin
            p = p | (p << s);
        end
        return p;
    endfunction

    // Capture the transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= t_func'(i_func);
            r_rank <= i_rank_in;
            r_suit <= i_suit_in;
            r_keep <= i_keep_in;
            r_pos  <= i_position;
        end
    end

    // Compare every cell against the operand in parallel
    always_comb begin
        for (int j = 0; j < DEPTH; j++) begin
            valid_v[j] = CMP_W'(j) < CMP_W'(r_count);
            gt_v[j]    = valid_v[j] &&
                         ({r_rank_c[j], r_suit_c[j]} > {r_rank, r_suit});
            match_v[j] = valid_v[j] &&
                         ({r_rank_c[j], r_suit_c[j]} == {r_rank, r_suit});
            unm_v[j]   = valid_v[j] && !r_keep_c[j];
            atpos_v[j] = CMP_W'(j) >= CMP_W'(r_pos);
        end
    end

    // Pick the affected cell range for the operation
    always_comb begin
        sel_v = '0;
        found = 1'b1;
        case (r_func) inside
            FN_INSERT: begin
                sel_v = gt_v | ~valid_v;
                found = CMP_W'(r_count) < CMP_W'(DEPTH);
            end
            FN_LOOKUP: begin
                found = |match_v;
            end
            FN_REM_POS, FN_MARK: begin
                sel_v = atpos_v;
                found = CMP_W'(r_pos) < CMP_W'(r_count);
            end
            FN_REM_UNM: begin
                sel_v = prefix_or(unm_v);
                found = |unm_v;
            end
            FN_REM_KEY: begin
                sel_v = prefix_or(match_v);
                found = |match_v;
            end
            default: begin
                sel_v = '0;
                found = 1'b1;
            end
        endcase
    end

    // Hold the evaluation for the apply step
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_sel   <= sel_v;
            r_found <= found;
        end
    end

    assign first_v = r_sel & ~(r_sel << 1);
    assign removes = r_found && ((r_func == FN_REM_POS) || (r_func == FN_REM_UNM) ||
                                 (r_func == FN_REM_KEY));

    // Select the entry at the first affected cell
    always_comb begin
        rem_rank = '0;
        rem_suit = '0;
        rem_keep = 1'b0;
        for (int j = 0; j < DEPTH; j++) begin
            rem_rank = rem_rank | (first_v[j] ? r_rank_c[j] : '0);
            rem_suit = rem_suit | (first_v[j] ? r_suit_c[j] : '0);
            rem_keep = rem_keep | (first_v[j] & r_keep_c[j]);
        end
    end

    // Result status and new count
    always_comb begin
        n_count    = r_count;
        res_status = ST_OK;
        case (r_func) inside
            FN_INSERT: begin
                res_status = r_found ? ST_OK : ST_FULL;
                if (r_found) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            FN_LOOKUP, FN_REM_UNM, FN_REM_KEY: begin
                res_status = r_found ? ST_OK : ST_NOT_FOUND;
            end
            FN_REM_POS, FN_MARK: begin
                res_status = r_found ? ST_OK : ST_BAD_POS;
            end
            default: begin
                res_status = ST_OK;
            end
        endcase
        if (removes) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Shift, fill or mark the cells
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && r_found) begin
            case (r_func) inside
                FN_INSERT: begin
                    if (first_v[0]) begin
                        r_rank_c[0] <= r_rank;
                        r_suit_c[0] <= r_suit;
                        r_keep_c[0] <= r_keep;
                    end
                    for (int j = 1; j < DEPTH; j++) begin
                        if (first_v[j]) begin
                            r_rank_c[j] <= r_rank;
                            r_suit_c[j] <= r_suit;
                            r_keep_c[j] <= r_keep;
                        end else if (r_sel[j]) begin
                            r_rank_c[j] <= r_rank_c[j-1];
                            r_suit_c[j] <= r_suit_c[j-1];
                            r_keep_c[j] <= r_keep_c[j-1];
                        end
                    end
                end
                FN_REM_POS, FN_REM_UNM, FN_REM_KEY: begin
                    for (int j = 0; j < DEPTH - 1; j++) begin
                        if (r_sel[j]) begin
                            r_rank_c[j] <= r_rank_c[j+1];
                            r_suit_c[j] <= r_suit_c[j+1];
                            r_keep_c[j] <= r_keep_c[j+1];
                        end
                    end
                end
                FN_MARK: begin
                    for (int j = 0; j < DEPTH; j++) begin
                        if (first_v[j]) begin
                            r_keep_c[j] <= 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.apply) begin
            r_count <= n_count;
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.apply) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_out_status <= res_status;
            r_out_rank   <= removes ? rem_rank : '0;
            r_out_suit   <= removes ? rem_suit : '0;
            r_out_keep   <= removes & rem_keep;
            r_out_empty  <= (n_count == '0);
            r_out_count  <= n_count;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_rank_out      = r_out_rank;
    assign o_suit_out      = r_out_suit;
    assign o_keep_out      = r_out_keep;
    assign o_is_empty      = r_out_empty;
    assign o_entry_count   = r_out_count;

endmodule

`default_nettype wire

// ----- tb/sorted_keyed_list_top_checker.sv -----
module sorted_keyed_list_top_checker
    import skl_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire               i_in_ready,
    input  wire [FUNC_W-1:0]  i_func,
    input  wire [RANK_W-1:0]  i_rank_in,
    input  wire [SUIT_W-1:0]  i_suit_in,
    input  wire               i_keep_in,
    input  wire [POS_W-1:0]   i_position,
    input  wire               i_out_valid,
    input  wire               i_out_ready,
    input  wire [STAT_W-1:0]  i_status,
    input  wire [RANK_W-1:0]  i_rank_out,
    input  wire [SUIT_W-1:0]  i_suit_out,
    input  wire               i_keep_out,
    input  wire               i_is_empty,
    input  wire [CNT_W-1:0]   i_entry_count,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_LIMIT = 30;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [RANK_W-1:0] rank;
        logic [SUIT_W-1:0] suit;
        logic              keep;
        logic              empty;
        logic [CNT_W-1:0]  count;
    } t_list_result;

    // Shadow copy of the sorted table
    logic [RANK_W-1:0] tbl_rank [DEPTH];
    logic [SUIT_W-1:0] tbl_suit [DEPTH];
    logic              tbl_keep [DEPTH];
    int                tbl_count;

    t_list_result expected_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        tbl_count    = 0;
    end

    task automatic report_mismatch(string msg);
        if (o_fail_count < PRINT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        o_fail_count++;
    endtask

    // Index of the first exact key match, or the count when there is none
    function automatic int find_key(logic [RANK_W-1:0] rk, logic [SUIT_W-1:0] st);
        int idx;
        for (idx = 0; idx < tbl_count; idx++) begin
            if (tbl_rank[idx] == rk && tbl_suit[idx] == st) begin
                return idx;
            end
        end
        return tbl_count;
    endfunction

    // Pull one entry out, close the gap and report what left
    function automatic t_list_result take_entry(int idx);
        t_list_result res;
        int j;
        res      = '0;
        res.rank = tbl_rank[idx];
        res.suit = tbl_suit[idx];
        res.keep = tbl_keep[idx];
        for (j = idx; j + 1 < tbl_count; j++) begin
            tbl_rank[j] = tbl_rank[j + 1];
            tbl_suit[j] = tbl_suit[j + 1];
            tbl_keep[j] = tbl_keep[j + 1];
        end
        tbl_count--;
        return res;
    endfunction

    // Apply one operation to the shadow table and build its result
    function automatic t_list_result apply_list_op(t_func op, logic [RANK_W-1:0] rk,
                                                   logic [SUIT_W-1:0] st, logic kp,
                                                   logic [POS_W-1:0] pos);
        t_list_result res;
        int idx;
        int j;
        res = '0;
        res.status = ST_OK;
        case (op)
            FN_INSERT: begin
                if (tbl_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    // land after every key that is not larger
                    idx = 0;
                    while (idx < tbl_count && {tbl_rank[idx], tbl_suit[idx]} <= {rk, st}) begin
                        idx++;
                    end
                    for (j = tbl_count; j > idx; j--) begin
                        tbl_rank[j] = tbl_rank[j - 1];
                        tbl_suit[j] = tbl_suit[j - 1];
                        tbl_keep[j] = tbl_keep[j - 1];
                    end
                    tbl_rank[idx] = rk;
                    tbl_suit[idx] = st;
                    tbl_keep[idx] = kp;
                    tbl_count++;
                end
            end
            FN_LOOKUP: begin
                res.status = (find_key(rk, st) < tbl_count) ? ST_OK : ST_NOT_FOUND;
            end
            FN_REM_POS: begin
                if (pos >= tbl_count) begin
                    res.status = ST_BAD_POS;
                end else begin
                    res = take_entry(int'(pos));
                end
            end
            FN_REM_UNM: begin
                idx = 0;
                while (idx < tbl_count && tbl_keep[idx]) begin
                    idx++;
                end
                if (idx < tbl_count) begin
                    res = take_entry(idx);
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
            FN_REM_KEY: begin
                idx = find_key(rk, st);
                if (idx < tbl_count) begin
                    res = take_entry(idx);
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
            FN_MARK: begin
                if (pos >= tbl_count) begin
                    res.status = ST_BAD_POS;
                end else begin
                    tbl_keep[pos] = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res.empty = (tbl_count == 0);
        res.count = tbl_count[CNT_W-1:0];
        return res;
    endfunction

    // Retire results first, then predict the newly accepted transaction
    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            tbl_count = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result transaction with no result pending");
                end else begin
                    want = expected_results.pop_front();
                    if (i_status !== want.status) begin
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  i_status, want.status));
                    end
                    if (i_rank_out !== want.rank) begin
                        report_mismatch($sformatf("rank_out got %0d want %0d",
                                                  i_rank_out, want.rank));
                    end
                    if (i_suit_out !== want.suit) begin
                        report_mismatch($sformatf("suit_out got %0d want %0d",
                                                  i_suit_out, want.suit));
                    end
                    if (i_keep_out !== want.keep) begin
                        report_mismatch($sformatf("keep_out got %0b want %0b",
                                                  i_keep_out, want.keep));
                    end
                    if (i_is_empty !== want.empty) begin
                        report_mismatch($sformatf("is_empty got %0b want %0b",
                                                  i_is_empty, want.empty));
                    end
                    if (i_entry_count !== want.count) begin
                        report_mismatch($sformatf("entry_count got %0d want %0d",
                                                  i_entry_count, want.count));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(apply_list_op(t_func'(i_func), i_rank_in,
                                                         i_suit_in, i_keep_in, i_position));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ----- tb/sorted_keyed_list_top_tb.sv -----
module sorted_keyed_list_top_tb;
    import skl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_OPS = 850;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_in_valid    = 1'b0;
    logic              o_in_ready;
    logic [FUNC_W-1:0] i_func        = '0;
    logic [RANK_W-1:0] i_rank_in     = '0;
    logic [SUIT_W-1:0] i_suit_in     = '0;
    logic              i_keep_in     = 1'b0;
    logic [POS_W-1:0]  i_position    = '0;
    logic              o_out_valid;
    logic              i_out_ready   = 1'b0;
    logic [STAT_W-1:0] o_status;
    logic [RANK_W-1:0] o_rank_out;
    logic [SUIT_W-1:0] o_suit_out;
    logic              o_keep_out;
    logic              o_is_empty;
    logic [CNT_W-1:0]  o_entry_count;

    int  fail_count;
    int  pending;
    bit  no_idle = 1'b0;
    int  ready_hold = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sorted_keyed_list_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_rank_in     (i_rank_in),
        .i_suit_in     (i_suit_in),
        .i_keep_in     (i_keep_in),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_rank_out    (o_rank_out),
        .o_suit_out    (o_suit_out),
        .o_keep_out    (o_keep_out),
        .o_is_empty    (o_is_empty),
        .o_entry_count (o_entry_count)
    );

    sorted_keyed_list_top_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_rank_in     (i_rank_in),
        .i_suit_in     (i_suit_in),
        .i_keep_in     (i_keep_in),
        .i_position    (i_position),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_status      (o_status),
        .i_rank_out    (o_rank_out),
        .i_suit_out    (o_suit_out),
        .i_keep_out    (o_keep_out),
        .i_is_empty    (o_is_empty),
        .i_entry_count (o_entry_count),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Result-side backpressure: mostly ready, short stalls, now and then a long one
    always @(posedge i_clk) begin
        int r;
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (no_idle) begin
            i_out_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                i_out_ready <= 1'b1;
                ready_hold  <= $urandom_range(0, 8);
            end else if (r < 93) begin
                i_out_ready <= 1'b0;
                ready_hold  <= $urandom_range(0, 3);
            end else begin
                i_out_ready <= 1'b0;
                ready_hold  <= $urandom_range(10, 30);
            end
        end
    end

    // Present one transaction, hold it until accepted, then sometimes idle for a while
    task automatic send_op(t_func op, logic [RANK_W-1:0] rk, logic [SUIT_W-1:0] st,
                           logic kp, logic [POS_W-1:0] pos);
        int r;
        int gap;
        i_in_valid <= 1'b1;
        i_func     <= op;
        i_rank_in  <= rk;
        i_suit_in  <= st;
        i_keep_in  <= kp;
        i_position <= pos;
        do @(posedge i_clk); while (!o_in_ready);
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) begin
            gap = 0;
        end else if (r < 90) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        #5_000_000;
        $display("sorted_keyed_list_top_tb failed");
        $finish;
    end

    initial begin
        int   seg_left;
        int   mode;
        int   r;
        t_func op;
        logic [RANK_W-1:0] rk;
        logic [SUIT_W-1:0] st;
        logic [POS_W-1:0]  pos;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table: every remove, lookup and mark comes back empty-handed
        send_op(FN_REM_POS, 4'd0,  3'd0, 1'b0, 4'd0);
        send_op(FN_REM_UNM, 4'd0,  3'd0, 1'b0, 4'd0);
        send_op(FN_REM_KEY, 4'd0,  3'd0, 1'b0, 4'd0);
        send_op(FN_LOOKUP,  4'd15, 3'd7, 1'b1, 4'd0);
        send_op(FN_MARK,    4'd0,  3'd0, 1'b0, 4'd15);
        // Extremes, an equal key and a suit tie-break
        send_op(FN_INSERT,  4'd15, 3'd7, 1'b1, 4'd15);
        send_op(FN_INSERT,  4'd0,  3'd0, 1'b0, 4'd0);
        send_op(FN_INSERT,  4'd7,  3'd3, 1'b0, 4'd0);
        send_op(FN_INSERT,  4'd7,  3'd3, 1'b1, 4'd0);
        send_op(FN_INSERT,  4'd7,  3'd2, 1'b0, 4'd0);
        send_op(FN_LOOKUP,  4'd7,  3'd3, 1'b0, 4'd0);
        send_op(FN_LOOKUP,  4'd7,  3'd4, 1'b0, 4'd0);
        // Mark twice: an already marked entry stays marked
        send_op(FN_MARK,    4'd0,  3'd0, 1'b0, 4'd0);
        send_op(FN_MARK,    4'd0,  3'd0, 1'b0, 4'd0);
        send_op(FN_REM_POS, 4'd0,  3'd0, 1'b0, 4'd4);
        send_op(FN_REM_POS, 4'd0,  3'd0, 1'b0, 4'd4);
        send_op(FN_REM_UNM, 4'd0,  3'd0, 1'b0, 4'd0);
        send_op(FN_REM_KEY, 4'd7,  3'd3, 1'b0, 4'd0);
        send_op(FN_REM_POS, 4'd0,  3'd0, 1'b0, 4'd0);
        send_op(FN_REM_UNM, 4'd0,  3'd0, 1'b0, 4'd0);
        send_op(FN_REM_KEY, 4'd7,  3'd3, 1'b0, 4'd0);
        send_op(FN_MARK,    4'd0,  3'd0, 1'b0, 4'd0);

        // Random segments that grow the table to full, drain it, or mix
        seg_left = 0;
        mode     = 0;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 60);
                mode     = $urandom_range(0, 2);
                no_idle  = ($urandom_range(0, 3) == 0);
            end
            seg_left--;
            r = $urandom_range(0, 99);
            if ((mode == 0 && r < 75) || (mode == 1 && r < 15)) begin
                op = FN_INSERT;
            end else if (mode == 2) begin
                op = t_func'($urandom_range(0, 5));
            end else begin
                op = t_func'($urandom_range(1, 5));
            end
            // narrow keys collide often so lookups and key removals hit
            if ($urandom_range(0, 1)) begin
                rk = 4'($urandom_range(0, 15));
                st = 3'($urandom_range(0, 7));
            end else begin
                rk = 4'($urandom_range(6, 8));
                st = 3'($urandom_range(0, 2));
            end
            pos = $urandom_range(0, 1) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
            send_op(op, rk, st, 1'($urandom_range(0, 1)), pos);
        end
        i_in_valid <= 1'b0;
        no_idle    = 1'b0;

        // Drain the remaining results, then watch for strays
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("sorted_keyed_list_top_tb passed");
        end else begin
            $display("sorted_keyed_list_top_tb failed");
        end
        $finish;
    end

endmodule

// ----- sorted_keyed_list_top.f -----
hdl/skl_pkg.sv
hdl/skl_ctrl.sv
hdl/skl_dp.sv
hdl/sorted_keyed_list_top.sv
tb/sorted_keyed_list_top_checker.sv
tb/sorted_keyed_list_top_tb.sv
